/* rtl/bb_pkg.sv */
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package bb_pkg;

  localparam int MaxWidthDefault = 1024;
  localparam int RowW            = 13;   // input row runs one past the frame during drain
  localparam int HeightW         = 12;
  localparam int WidthRegW       = 11;
  localparam int SumW            = 12;   // 9 * 255
  localparam int RecipW          = 24;
  localparam int QueueDepth      = 4;

  localparam logic [0:0] OpPixel = 1'b0;
  localparam logic [0:0] OpDrain = 1'b1;

  localparam logic [0:0] RegFrameWidth  = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // One window column: upper, middle and newest row.
  typedef struct packed {
    pixel_t up;
    pixel_t mid;
    pixel_t px;
  } column_t;

  // What the front hands to the back for each window shift.
  typedef struct packed {
    column_t    col;
    logic       emit;
    logic       eof;
    logic [2:0] cmask;   // left, center, right column inside the frame
    logic [2:0] rmask;   // upper, middle, lower row inside the frame
  } item_t;

  // ceil(2^24 / (2n)) for the neighbour counts that occur.
  function automatic logic [RecipW-1:0] mean_recip(input logic [3:0] n);
    logic [RecipW-1:0] m;
    begin
      unique case (n)
        4'd1:    m = 24'd8388608;
        4'd2:    m = 24'd4194304;
        4'd3:    m = 24'd2796203;
        4'd4:    m = 24'd2097152;
        4'd6:    m = 24'd1398102;
        4'd9:    m = 24'd932068;
        default: m = 24'd0;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/bb_front.sv */
// Front end: accepts pixels and drain ticks, tracks frame position, owns the
// two line stores and classifies each item for the back end. Uses bb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bb_front
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr,
  input  wire logic [WidthRegW-1:0] frame_width,
  input  wire logic [HeightW-1:0]   frame_height,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [0:0]           in_op,
  input  wire pixel_t               in_pixel,
  output logic                      push,
  output item_t                     push_item,
  input  wire logic                 q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  pixel_t mem_up  [MAX_WIDTH];
  pixel_t mem_mid [MAX_WIDTH];

  logic [CW-1:0]      col;
  logic [RowW-1:0]    row;
  logic [CW-1:0]      ocol;
  logic [HeightW-1:0] orow;

  pixel_t rd_up, rd_mid, byp_up, byp_mid;
  logic   byp;

  logic [WW-1:0]      w_eff;
  logic [HeightW-1:0] h_eff;
  logic [31:0]        w32;
  logic [CW-1:0]      c, col_next, rd_addr;
  logic               in_frame, act, last_col, emit, eof;
  pixel_t             px, up, mid;

  always_comb begin
    w32 = 32'(frame_width);
    if (w32 == 32'd0) begin
      w_eff = WW'(1);
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w32);
    end
    h_eff = (frame_height == '0) ? HeightW'(1) : frame_height;
  end

  assign in_ready = !q_full;
  assign in_frame = row < RowW'(h_eff);
  // drain ticks inside the frame are dropped without effect
  assign act      = in_valid && in_ready && !(in_frame && in_op == OpDrain);
  assign px       = in_frame ? in_pixel : '0;
  assign c        = ({1'b0, col} >= w_eff) ? '0 : col;
  assign last_col = (WW'({1'b0, c}) + WW'(1)) >= w_eff;
  assign emit     = (row >= RowW'(2)) || (row == RowW'(1) && c != '0);
  assign eof      = emit && (orow + HeightW'(1) >= h_eff)
                    && (WW'({1'b0, ocol}) + WW'(1) >= w_eff);
  assign col_next = (eof || last_col) ? '0 : c + CW'(1);
  assign up       = byp ? byp_up : rd_up;
  assign mid      = byp ? byp_mid : rd_mid;

  always_comb begin
    if (rst || cfg_wr) begin
      rd_addr = '0;
    end else if (act) begin
      rd_addr = col_next;
    end else begin
      rd_addr = col;
    end
  end

  // line stores: write the shifted column, prefetch the next one
  always_ff @(posedge clk) begin
    if (act) begin
      mem_up[c]  <= mid;
      mem_mid[c] <= px;
    end
    rd_up   <= mem_up[rd_addr];
    rd_mid  <= mem_mid[rd_addr];
    byp     <= act && (c == rd_addr);
    byp_up  <= mid;
    byp_mid <= px;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col  <= '0;
      row  <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (act) begin
      if (eof) begin
        col  <= '0;
        row  <= '0;
        ocol <= '0;
        orow <= '0;
      end else begin
        col <= col_next;
        if (last_col) begin
          row <= row + RowW'(1);
        end
        if (emit) begin
          if (WW'({1'b0, ocol}) + WW'(1) >= w_eff) begin
            ocol <= '0;
            orow <= orow + HeightW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    push                 = act;
    push_item.col.up     = up;
    push_item.col.mid    = mid;
    push_item.col.px     = px;
    push_item.emit       = emit;
    push_item.eof        = eof;
    push_item.cmask[0]   = ocol != '0;
    push_item.cmask[1]   = 1'b1;
    push_item.cmask[2]   = (WW'({1'b0, ocol}) + WW'(1)) < w_eff;
    push_item.rmask[0]   = orow != '0;
    push_item.rmask[1]   = 1'b1;
    push_item.rmask[2]   = (orow + HeightW'(1)) < h_eff;
  end

endmodule
`default_nettype wire

/* rtl/bb_queue.sv */
// Short register queue between the front and back ends.
// Uses bb_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module bb_queue
  import bb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty,
  output logic       full
);

  localparam int PW = $clog2(QueueDepth);

  item_t         slots [QueueDepth];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign empty = count == '0;
  assign full  = count == (PW+1)'(QueueDepth);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue underflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> !empty)
    else $error("queue lost an entry");
`endif

endmodule
`default_nettype wire

/* rtl/bb_back.sv */
// Back end: shifts the 3x3 window, sums the in-frame neighbours, divides by
// reciprocal multiply and holds the result register. Uses bb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bb_back
  import bb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr,
  input  wire item_t head,
  input  wire logic  empty,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output pixel_t     out_pixel,
  output logic       out_last
);

  column_t c1, c2;
  column_t cols [3];

  logic              s1_valid, s1_eof;
  logic [SumW-1:0]   s1_sum [3];
  logic [3:0]        s1_n;
  logic [RecipW-1:0] s1_m;

  logic [SumW-1:0]   sum [3];
  logic [1:0]        nc, nr;
  logic [3:0]        n;
  logic              out_free, s1_adv;
  logic [SumW:0]     x [3];
  logic [SumW+RecipW:0] prod [3];
  pixel_t            p;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || out_free;
  assign pop      = !empty && s1_adv;

  always_comb begin
    cols[0] = c1;
    cols[1] = c2;
    cols[2] = head.col;
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      for (int t = 0; t < 3; t++) begin
        unique case (t)
          0:       p = cols[j].up;
          1:       p = cols[j].mid;
          default: p = cols[j].px;
        endcase
        if (head.cmask[j] && head.rmask[t]) begin
          sum[0] = sum[0] + SumW'(p.r);
          sum[1] = sum[1] + SumW'(p.g);
          sum[2] = sum[2] + SumW'(p.b);
        end
      end
    end
    nc = 2'($countones(head.cmask));
    nr = 2'($countones(head.rmask));
    n  = 4'({2'b00, nc} * {2'b00, nr});
  end

  // round half up: (2*sum + n) * ceil(2^24 / 2n) >> 24
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      x[ch]    = {s1_sum[ch], 1'b0} + (SumW+1)'(s1_n);
      prod[ch] = (SumW+RecipW+1)'(x[ch]) * (SumW+RecipW+1)'(s1_m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      c1 <= '0;
      c2 <= '0;
    end else if (pop) begin
      if (head.eof) begin
        c1 <= '0;
        c2 <= '0;
      end else begin
        c1 <= c2;
        c2 <= head.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= pop && head.emit;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && s1_adv) begin
      s1_sum <= sum;
      s1_n   <= n;
      s1_m   <= mean_recip(n);
      s1_eof <= head.eof;
    end
    if (out_free) begin
      out_pixel.r <= prod[0][RecipW+7:RecipW];
      out_pixel.g <= prod[1][RecipW+7:RecipW];
      out_pixel.b <= prod[2][RecipW+7:RecipW];
      out_last    <= s1_eof;
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.eof) |=> (c1 == '0 && c2 == '0))
    else $error("window not cleared at end of frame");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_m) && $stable(s1_eof)))
    else $error("stage one lost a result under stall");
  a_eof_emits: assert property (@(posedge clk) disable iff (rst)
    (pop && head.eof) |-> head.emit)
    else $error("end of frame on an item without a result");
`endif

endmodule
`default_nettype wire

/* rtl/box_blur_3x3_edge_aware_top.sv */
// 3x3 edge-aware box blur. A pixel's result leaves one row plus one pixel of
// items after it; the item that completes it passes the queue, stage one and the
// result register before raising m_tvalid. The line-store prefetch lets it take
// one item per cycle while the 4-entry front/back queue is not full.
// Reset (rst, synchronous) clears counters, window, queue and valid flags;
// line stores are not cleared (no clearing pass), registers return to 640x480.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_edge_aware_top
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
  input  wire logic [0:0]  s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
  output logic             m_tlast,   // end_of_frame
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [WidthRegW-1:0] frame_width;
  logic [HeightW-1:0]   frame_height;
  logic                 cfg_wr, push, pop, q_empty, q_full;
  item_t                push_item, head;
  pixel_t               in_pixel, out_pixel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WidthRegW'(640);
      frame_height <= HeightW'(480);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegFrameWidth:  frame_width  <= pwdata[WidthRegW-1:0];
        RegFrameHeight: frame_height <= pwdata[HeightW-1:0];
        default:        frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegFrameWidth:  prdata = 32'(frame_width);
      RegFrameHeight: prdata = 32'(frame_height);
      default:        prdata = '0;
    endcase
  end

  assign in_pixel.r = s_tdata[7:0];
  assign in_pixel.g = s_tdata[15:8];
  assign in_pixel.b = s_tdata[23:16];

  bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_wr),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op        (s_tuser),
    .in_pixel     (in_pixel),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  bb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  bb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (out_pixel),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_pixel.b, out_pixel.g, out_pixel.r};

endmodule
`default_nettype wire

/* tb/sv/tb_box_blur_3x3_edge_aware_top.sv */
// Testbench for the 3x3 edge-aware box blur: a stream driver and monitor checked
// against an in-bench blur predictor. Depends on bb_pkg and box_blur_3x3_edge_aware_top.
`timescale 1ns / 1ps
module tb_box_blur_3x3_edge_aware_top;
  import bb_pkg::*;

  typedef enum logic [1:0] {ReqPixel, ReqCfg, ReqPause} req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [0:0]  op;
    pixel_t      px;
    logic [2:0]  addr;
    logic [31:0] data;
  } req_t;

  typedef struct {
    pixel_t px;
    logic   eof;
  } blur_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_3x3_edge_aware_top i_dut (.*);

  always #4 clk = ~clk;

  // blur predictor state
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  pixel_t      upper_line [1024];
  pixel_t      middle_line [1024];
  pixel_t      win [3][3];
  int          in_col, in_row, out_pos;

  req_t  pending_reqs [$];
  blur_t expected_blurs [$];
  int    mismatches = 0;
  int    pixels_queued = 0;
  bit    no_gaps = 0;

  // size in force once every queued write has landed
  int    last_w = 4;
  int    last_h = 4;

  function automatic int eff_w();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > 1024) w = 1024;
    return w;
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  task automatic restart_frame();
    for (int j = 0; j < 3; j++)
      for (int t = 0; t < 3; t++) win[j][t] = '0;
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endtask

  task automatic blur_config(input logic [2:0] addr, input logic [31:0] data);
    if (addr == 3'(RegFrameWidth) * 4) width_reg = data[10:0];
    else if (addr == 3'(RegFrameHeight) * 4) height_reg = data[11:0];
    restart_frame();
  endtask

  task automatic blur_step(input logic [0:0] op, input pixel_t in_px);
    int w, h, c, k, orow, ocol, n;
    int sr, sg, sb;
    pixel_t px, p;
    bit colok [3], rowok [3];
    blur_t res;
    w = eff_w();
    h = eff_h();
    px = '0;
    if (in_row < h) begin
      if (op == OpDrain) return;
      px = in_px;
    end
    c = (in_col >= w) ? 0 : in_col;
    k = in_row * w + c;
    for (int j = 0; j < 2; j++)
      for (int t = 0; t < 3; t++) win[j][t] = win[j + 1][t];
    win[2][0] = upper_line[c];
    win[2][1] = middle_line[c];
    win[2][2] = px;
    upper_line[c] = middle_line[c];
    middle_line[c] = px;
    if (c + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = c + 1;
    end
    if (k < w + 1) return;
    orow = out_pos / w;
    ocol = out_pos % w;
    colok[0] = ocol > 0;
    colok[1] = 1;
    colok[2] = ocol + 1 < w;
    rowok[0] = orow > 0;
    rowok[1] = 1;
    rowok[2] = orow + 1 < h;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int j = 0; j < 3; j++)
      for (int t = 0; t < 3; t++)
        if (colok[j] && rowok[t]) begin
          p = win[j][t];
          sr += p.r; sg += p.g; sb += p.b;
          n++;
        end
    res.px.r = 8'((2 * sr + n) / (2 * n));
    res.px.g = 8'((2 * sg + n) / (2 * n));
    res.px.b = 8'((2 * sb + n) / (2 * n));
    if (out_pos + 1 >= w * h) begin
      res.eof = 1'b1;
      restart_frame();
    end else begin
      res.eof = 1'b0;
      out_pos++;
    end
    expected_blurs.push_back(res);
  endtask

  function automatic pixel_t rand_px();
    pixel_t p;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      default: p = pixel_t'(24'($urandom));
    endcase
    return p;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(input logic [0:0] op, input pixel_t px);
    req_t q;
    q.kind = ReqPixel; q.op = op; q.px = px; q.addr = '0; q.data = '0;
    pending_reqs.push_back(q);
    pixels_queued++;
  endtask

  task automatic push_ctl(input req_kind_t kind, input logic [2:0] addr,
                          input logic [31:0] data);
    req_t q;
    q.kind = kind; q.op = OpPixel; q.px = '0; q.addr = addr; q.data = data;
    pending_reqs.push_back(q);
  endtask

  // Set both registers from raw values; junk above the field width must be ignored.
  task automatic push_size(input int w_raw, input int h_raw);
    int wf, hf;
    wf = w_raw & 'h7ff;
    hf = h_raw & 'hfff;
    push_ctl(ReqCfg, 3'(RegFrameWidth) * 4, {$urandom} << 11 | 32'(wf));
    push_ctl(ReqCfg, 3'(RegFrameHeight) * 4, {$urandom} << 12 | 32'(hf));
    last_w = (wf == 0) ? 1 : (wf > 1024) ? 1024 : wf;
    last_h = (hf == 0) ? 1 : hf;
  endtask

  // One frame of pixels with stray drains, then the drain tail. A cut frame
  // stops early; the following config write drops what is left.
  task automatic push_frame(input int w, input int h, input bit cut);
    int stop;
    stop = cut ? $urandom_range(0, w * h + w) : w * h + w + 1;
    for (int i = 0; i < w * h + w + 1 && i < stop; i++) begin
      if (i < w * h) begin
        if ($urandom_range(0, 19) == 0) push_item(OpDrain, rand_px());
        push_item(OpPixel, rand_px());
      end else begin
        push_item(($urandom_range(0, 4) == 0) ? OpPixel : OpDrain, rand_px());
      end
    end
    if (!cut && $urandom_range(0, 5) == 0) push_item(OpDrain, rand_px());
  endtask

  // driver
  int gap = 0;
  int settle = 0;
  int apb_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else begin
      bit hold;
      hold = s_tvalid;
      if (s_tvalid && s_tready) begin
        blur_step(pending_reqs[0].op, pending_reqs[0].px);
        void'(pending_reqs.pop_front());
        hold = 0;
        gap = rand_gap();
      end
      if (apb_phase == 1) begin
        penable <= 1'b1;
        apb_phase = 2;
      end else if (apb_phase == 2) begin
        psel <= 1'b0;
        penable <= 1'b0;
        blur_config(pending_reqs[0].addr, pending_reqs[0].data);
        void'(pending_reqs.pop_front());
        apb_phase = 0;
      end else if (!hold && pending_reqs.size() > 0) begin
        if (pending_reqs[0].kind == ReqPixel) begin
          if (gap > 0) begin
            gap--;
          end else begin
            hold = 1;
            s_tdata <= {pending_reqs[0].px.b, pending_reqs[0].px.g, pending_reqs[0].px.r};
            s_tuser <= pending_reqs[0].op;
          end
        end else if (expected_blurs.size() == 0) begin
          // let the pipe empty before a write or after a pause
          if (settle < 20) begin
            settle++;
          end else begin
            settle = 0;
            if (pending_reqs[0].kind == ReqPause) begin
              void'(pending_reqs.pop_front());
            end else begin
              psel <= 1'b1;
              pwrite <= 1'b1;
              paddr <= pending_reqs[0].addr;
              pwdata <= pending_reqs[0].data;
              apb_phase = 1;
            end
          end
        end
      end
      s_tvalid <= hold;
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_blurs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h last %b", m_tdata, m_tlast);
        end else begin
          blur_t e;
          e = expected_blurs.pop_front();
          if (m_tdata[7:0] !== e.px.r || m_tdata[15:8] !== e.px.g ||
              m_tdata[23:16] !== e.px.b || m_tlast !== e.eof) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rgb %h %h %h last %b, got rgb %h %h %h last %b",
                       e.px.r, e.px.g, e.px.b, e.eof,
                       m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
          end
        end
      end
      // mostly short backpressure, now and then a long stall
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 99) < 3) begin
        stall = $urandom_range(10, 40);
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_gaps || ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int w, h;
    width_reg = 11'd640;
    height_reg = 12'd480;
    for (int i = 0; i < 1024; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    restart_frame();

    // directed: tiny frames, extreme colors, width and height out of range
    push_size(3, 3);
    push_item(OpDrain, '1);
    for (int i = 0; i < 9; i++) push_item(OpPixel, (i % 2) ? pixel_t'('1) : pixel_t'('0));
    for (int i = 0; i < 4; i++) push_item((i == 1) ? OpPixel : OpDrain, '1);
    push_item(OpDrain, '0);
    push_size(0, 0);
    push_item(OpPixel, '1);
    push_item(OpDrain, '0);
    push_item(OpDrain, '0);
    push_ctl(ReqPause, '0, '0);
    push_size(2, 2);
    push_frame(2, 2, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // width above the limit and the tallest frame, each cut short by the next write
    push_size(2047, 2);
    for (int i = 0; i < 60; i++) push_item(OpPixel, rand_px());
    push_size(1, 4095);
    for (int i = 0; i < 60; i++) push_item(OpPixel, rand_px());
    push_size(4, 4);

    while (pixels_queued < 700) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) push_size(w, h);
      else begin
        w = last_w;
        h = last_h;
      end
      no_gaps = ($urandom_range(0, 5) == 0);
      push_frame(w, h, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) push_ctl(ReqPause, '0, '0);
      while (pending_reqs.size() > 200) @(posedge clk);
    end
    // the next write ends any cut frame
    push_size(4, 4);

    while (pending_reqs.size() > 0 || expected_blurs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_blurs.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/bb_pkg.sv
rtl/bb_front.sv
rtl/bb_queue.sv
rtl/bb_back.sv
rtl/box_blur_3x3_edge_aware_top.sv
tb/sv/tb_box_blur_3x3_edge_aware_top.sv
